>>> rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, disabled while reset is asserted.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error(msg);

// Implication form built on the clocked macro.
`define ASSERT_IMPLY(label, clk, rst_n, lhs, rhs, msg) \
	`ASSERT_CLK(label, clk, rst_n, (lhs) |-> (rhs), msg)

// Next-cycle implication form built on the clocked macro.
`define ASSERT_NEXT(label, clk, rst_n, lhs, rhs, msg) \
	`ASSERT_CLK(label, clk, rst_n, (lhs) |=> (rhs), msg)

`endif

>>> rtl/dsci_pkg.sv
`default_nettype none
package dsci_pkg;

	localparam int MANT_BITS_DEF = 64;
	localparam int EXP_W         = 14;
	localparam int FRAC_W        = 10;
	localparam int DEXP_W        = 15;
	localparam int EXPW_W        = 17;

	localparam logic [EXP_W-1:0]  EXP_MAX  = EXP_W'(9999);
	localparam logic [FRAC_W-1:0] FRAC_MAX = '1;

	localparam logic [7:0] CH_MINUS = 8'h2d;
	localparam logic [7:0] CH_PLUS  = 8'h2b;
	localparam logic [7:0] CH_POINT = 8'h2e;
	localparam logic [7:0] CH_UPPER_E = 8'h45;
	localparam logic [7:0] CH_LOWER_E = 8'h65;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0d;
	localparam logic [7:0] CH_SPACE = 8'h20;

	typedef enum logic [2:0] {
		PH_WS      = 3'd0,
		PH_SIGN    = 3'd1,
		PH_INT     = 3'd2,
		PH_FRAC    = 3'd3,
		PH_EXP0    = 3'd4,
		PH_EXPSIGN = 3'd5,
		PH_EXPDIG  = 3'd6
	} phase_t;

endpackage
`default_nettype wire

>>> rtl/dsci_core.sv
`default_nettype none
module dsci_core #(
	parameter int MANT_BITS = dsci_pkg::MANT_BITS_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        ch_valid,
	input  wire logic [7:0]                  ch,
	output logic                             emit,
	output logic                             negative,
	output logic [MANT_BITS-1:0]             mantissa,
	output logic [dsci_pkg::DEXP_W-1:0]      dec_exponent,
	output logic                             saturated
);
	import dsci_pkg::*;

	phase_t                phase_q, phase_d;
	logic                  sign_neg_q, sign_neg_d;
	logic [MANT_BITS-1:0]  acc_q, acc_d;
	logic [FRAC_W-1:0]     frac_q, frac_d;
	logic                  exp_neg_q, exp_neg_d;
	logic [EXP_W-1:0]      exp_q, exp_d;
	logic                  sat_q, sat_d;

	logic                  is_dig, is_e, is_ws, is_sign, is_dot;
	logic [3:0]            dval;
	logic [MANT_BITS+3:0]  mant_wide;
	logic                  mant_ovf;
	logic [EXPW_W-1:0]     exp_wide;
	logic                  exp_ovf;
	logic [DEXP_W-1:0]     exp_signed;

	assign is_dig  = (ch >= CH_ZERO) && (ch <= CH_NINE);
	assign is_e    = (ch == CH_UPPER_E) || (ch == CH_LOWER_E);
	assign is_ws   = ((ch >= CH_TAB) && (ch <= CH_CR)) || (ch == CH_SPACE);
	assign is_sign = (ch == CH_MINUS) || (ch == CH_PLUS);
	assign is_dot  = (ch == CH_POINT);
	assign dval    = is_dig ? 4'(ch - CH_ZERO) : 4'd0;

	// acc*10 + d; any bit above the mantissa width means overflow
	assign mant_wide = {1'b0, acc_q, 3'b000} + {3'b000, acc_q, 1'b0}
		+ {{MANT_BITS{1'b0}}, dval};
	assign mant_ovf  = |mant_wide[MANT_BITS+3:MANT_BITS];

	assign exp_wide = {exp_q, 3'b000} + {2'b00, exp_q, 1'b0} + {13'd0, dval};
	assign exp_ovf  = exp_wide > {3'b000, EXP_MAX};

	// Outputs: terminating character detection and result fields
	always_comb begin
		case (phase_q)
			PH_WS:                 emit = !is_ws && !is_sign && !is_dig && !is_dot && !is_e;
			PH_SIGN, PH_INT:       emit = !is_dig && !is_dot && !is_e;
			PH_FRAC:               emit = !is_dig && !is_e;
			PH_EXP0:               emit = !is_sign && !is_dig;
			PH_EXPSIGN, PH_EXPDIG: emit = !is_dig;
			default:               emit = 1'b1;
		endcase
	end

	always_comb begin
		exp_signed   = exp_neg_q ? (DEXP_W'(0) - {1'b0, exp_q}) : {1'b0, exp_q};
		dec_exponent = exp_signed - {{(DEXP_W-FRAC_W){1'b0}}, frac_q};
		negative     = sign_neg_q;
		mantissa     = acc_q;
		saturated    = sat_q;
	end

	// Next state
	always_comb begin
		phase_d    = phase_q;
		sign_neg_d = sign_neg_q;
		acc_d      = acc_q;
		frac_d     = frac_q;
		exp_neg_d  = exp_neg_q;
		exp_d      = exp_q;
		sat_d      = sat_q;
		if (emit) begin
			phase_d    = PH_WS;
			sign_neg_d = 1'b0;
			acc_d      = '0;
			frac_d     = '0;
			exp_neg_d  = 1'b0;
			exp_d      = '0;
			sat_d      = 1'b0;
		end else begin
			case (phase_q)
				PH_WS, PH_SIGN, PH_INT: begin
					if (phase_q == PH_WS && is_ws) begin
						phase_d = PH_WS;
					end else if (phase_q == PH_WS && is_sign) begin
						sign_neg_d = (ch == CH_MINUS);
						phase_d    = PH_SIGN;
					end else if (is_dig) begin
						acc_d   = mant_ovf ? '1 : mant_wide[MANT_BITS-1:0];
						sat_d   = sat_q | mant_ovf;
						phase_d = PH_INT;
					end else if (is_dot) begin
						phase_d = PH_FRAC;
					end else begin
						phase_d = PH_EXP0;
					end
				end
				PH_FRAC: begin
					if (is_dig) begin
						acc_d = mant_ovf ? '1 : mant_wide[MANT_BITS-1:0];
						if (frac_q == FRAC_MAX) begin
							sat_d = 1'b1;
						end else begin
							frac_d = frac_q + FRAC_W'(1);
							sat_d  = sat_q | mant_ovf;
						end
					end else begin
						phase_d = PH_EXP0;
					end
				end
				PH_EXP0, PH_EXPSIGN, PH_EXPDIG: begin
					if (phase_q == PH_EXP0 && is_sign) begin
						exp_neg_d = (ch == CH_MINUS);
						phase_d   = PH_EXPSIGN;
					end else begin
						exp_d   = exp_ovf ? EXP_MAX : exp_wide[EXP_W-1:0];
						sat_d   = sat_q | exp_ovf;
						phase_d = PH_EXPDIG;
					end
				end
				default: phase_d = PH_WS;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_WS;
			sign_neg_q <= 1'b0;
			acc_q      <= '0;
			frac_q     <= '0;
			exp_neg_q  <= 1'b0;
			exp_q      <= '0;
			sat_q      <= 1'b0;
		end else if (ch_valid) begin
			phase_q    <= phase_d;
			sign_neg_q <= sign_neg_d;
			acc_q      <= acc_d;
			frac_q     <= frac_d;
			exp_neg_q  <= exp_neg_d;
			exp_q      <= exp_d;
			sat_q      <= sat_d;
		end
	end

endmodule
`default_nettype wire

>>> rtl/decimal_scientific_parse.sv
// Streaming decimal parser with scientific notation.
// Input channel s_axis_*: one ASCII character per beat in tdata[7:0].
// Output channel m_axis_*: one beat per parsed number, sent when the first
// character that does not fit the number form is accepted. That character
// is consumed; parsing restarts with the next beat.
// The result is registered into the output slot, or into the skid entry if stalled.
// Throughput: one character per cycle while s_axis_tready is high; the digit
// accumulate (times ten plus digit over the mantissa width) sets the critical path.
// Stall: an output register plus one skid entry hold results, so input is
// still taken while one result waits; s_axis_tready falls only when both
// are full and rises again the cycle after m_axis_tready is seen.
// Reset (arst_n low): parser returns to the leading-whitespace phase with
// all accumulators cleared, and both result slots are emptied.
// Result fields: negative sign, MANT_BITS-bit mantissa (saturating), a
// 15-bit two's complement base-ten exponent, and a saturation flag.
`default_nettype none
module decimal_scientific_parse #(
	parameter int MANT_BITS = dsci_pkg::MANT_BITS_DEF,
	localparam int OUT_W    = ((MANT_BITS + dsci_pkg::DEXP_W + 2 + 7) / 8) * 8
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             s_axis_tvalid,
	output logic                  s_axis_tready,
	input  wire logic [7:0]       s_axis_tdata,   // [7:0] ch
	output logic                  m_axis_tvalid,
	input  wire logic             m_axis_tready,
	output logic [OUT_W-1:0]      m_axis_tdata    // negative, mantissa, dec_exponent, saturated
);
	import dsci_pkg::*;

	localparam int RES_W = MANT_BITS + DEXP_W + 2;

	logic                 accept;
	logic                 emit;
	logic                 negative;
	logic [MANT_BITS-1:0] mantissa;
	logic [DEXP_W-1:0]    dec_exponent;
	logic                 saturated;
	logic [RES_W-1:0]     res;

	logic                 out_valid_q, skid_valid_q;
	logic [RES_W-1:0]     out_data_q, skid_data_q;

	assign s_axis_tready = !skid_valid_q;
	assign accept        = s_axis_tvalid && s_axis_tready;

	dsci_core #(.MANT_BITS(MANT_BITS)) u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.ch_valid     (accept),
		.ch           (s_axis_tdata),
		.emit         (emit),
		.negative     (negative),
		.mantissa     (mantissa),
		.dec_exponent (dec_exponent),
		.saturated    (saturated)
	);

	assign res = {saturated, dec_exponent, mantissa, negative};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			// drain the skid entry into the output slot
			if (m_axis_tready) begin
				skid_valid_q <= 1'b0;
			end
		end else if (accept && emit) begin
			if (out_valid_q && !m_axis_tready) begin
				skid_valid_q <= 1'b1;
			end else begin
				out_valid_q <= 1'b1;
			end
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (m_axis_tready) begin
				out_data_q <= skid_data_q;
			end
		end else if (accept && emit) begin
			if (out_valid_q && !m_axis_tready) begin
				skid_data_q <= res;
			end else begin
				out_data_q <= res;
			end
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{(OUT_W-RES_W){1'b0}}, out_data_q};

endmodule
`default_nettype wire

>>> rtl/dsci_checker.sv
`default_nettype none
`include "assert_macros.svh"
module dsci_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic s_axis_tvalid,
	input wire logic s_axis_tready,
	input wire logic m_axis_tvalid,
	input wire logic m_axis_tready
);

	// a waiting result stays offered until taken
	`ASSERT_NEXT(a_out_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "output beat dropped while stalled")

	// results appear only after an input beat
	`ASSERT_IMPLY(a_out_cause, clk, arst_n, $rose(m_axis_tvalid), $past(s_axis_tvalid && s_axis_tready), "result without input beat")

	// input is blocked only while a result is waiting
	`ASSERT_IMPLY(a_block_full, clk, arst_n, !s_axis_tready, m_axis_tvalid, "input blocked with empty output")

	// one taken output beat frees the skid entry
	`ASSERT_NEXT(a_skid_drain, clk, arst_n, !s_axis_tready && m_axis_tready, s_axis_tready, "skid entry not drained")

endmodule

bind decimal_scientific_parse dsci_checker u_dsci_checker (.*);
`default_nettype wire
